@@ hw/rtl/rainbow_reduction_index_to_text_top_macros.svh @@
// Assertion macros used by the checker file of the rainbow reduction block.
// Depends on nothing; included by bare file name.
`ifndef RAINBOW_REDUCTION_INDEX_TO_TEXT_TOP_MACROS_SVH
`define RAINBOW_REDUCTION_INDEX_TO_TEXT_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define RRIT_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rrit assertion failed");

// Next-cycle implication, disabled during reset
`define RRIT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rrit assertion failed");

`endif

@@ hw/rtl/rrit_pkg.sv @@
// Package for the rainbow reduction block: widths, register map, reset values,
// divider command type and the length clamp. Depends on nothing.
package rrit_pkg;

  localparam int MAX_LEN     = 16;
  localparam int WORD_W      = 64;
  localparam int COL_W       = 16;
  localparam int ALPHA_W     = 9;
  localparam int LEN_W       = 5;
  localparam int POS_W       = 4;
  localparam int SYM_W       = 8;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 64;
  localparam int NARROW_BITS = 8;
  localparam int DIV_CNT_W   = 7;

  // Register indexes, placed at byte address 8*i
  typedef enum logic [1:0] {
    REG_ALPHABET = 2'd0,
    REG_MIN_LEN  = 2'd1,
    REG_MAX_LEN  = 2'd2,
    REG_SPACE    = 2'd3
  } reg_idx_t;

  localparam logic [ALPHA_W-1:0] ALPHABET_RST = 9'd26;
  localparam logic [LEN_W-1:0]   MIN_LEN_RST  = 5'd1;
  localparam logic [LEN_W-1:0]   MAX_LEN_RST  = 5'd6;
  localparam logic [WORD_W-1:0]  SPACE_RST    = 64'd321272406;

  // Command to the shared divider
  typedef struct packed {
    logic start;
    logic narrow;
  } div_cmd_t;

  // Clamp a length register to 1..MAX_LEN
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    if (v == '0) begin
      return LEN_W'(1);
    end else if (v > LEN_W'(MAX_LEN)) begin
      return LEN_W'(MAX_LEN);
    end
    return v;
  endfunction

endpackage

@@ hw/rtl/rrit_ifs.sv @@
// Valid/ready channel interfaces for the digest input and the symbol output.
// Depends on rrit_pkg.
interface rrit_digest_if;
  import rrit_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] digest_word;
  logic [COL_W-1:0]  column;
  modport source (output valid, digest_word, column, input ready);
  modport sink   (input valid, digest_word, column, output ready);
endinterface

interface rrit_text_if;
  import rrit_pkg::*;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic [POS_W-1:0] position;
  logic             is_last;
  modport source (output valid, symbol, position, is_last, input ready);
  modport sink   (input valid, symbol, position, is_last, output ready);
endinterface

@@ hw/rtl/rainbow_reduction_index_to_text_top.sv @@
// Top level of the rainbow reduction block: register port, sequencer and
// output register. Depends on rrit_pkg, rrit_ifs and rrit_div.
//
// Takes one digest word and column, reduces their sum modulo space_size, picks
// the text length and emits its symbols from the last position down to zero,
// one transfer per symbol, is_last on position zero. One item is worked at a
// time and the input is not ready until its last symbol is in the output
// register. An item is taken in, reduced by the modulo (skipped when
// space_size is 0), then the first count is formed, the lengths are
// stepped over until the search ends, and each symbol is formed and
// emitted while the output register is free. The modulo and the digits run
// through one shared divider: the modulo retires one quotient bit per cycle,
// each symbol eight quotient bits per cycle; a stalled output holds the
// symbol until the register is free. Registers sit at byte address 8*i:
// radix, min_length, max_length, space_size.
module rainbow_reduction_index_to_text_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rrit_pkg::ADDR_W-1:0]  paddr,
  input  logic [rrit_pkg::DATA_W-1:0]  pwdata,
  output logic [rrit_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  rrit_digest_if.sink                  digest,
  rrit_text_if.source                  text
);
  import rrit_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD_START,
    S_MOD_WAIT,
    S_POW,
    S_SEARCH,
    S_DIG_START,
    S_DIG_WAIT,
    S_EMIT
  } state_t;

  // Configuration registers
  logic [ALPHA_W-1:0] radix;
  logic [LEN_W-1:0]   min_length;
  logic [LEN_W-1:0]   max_length;
  logic [WORD_W-1:0]  space_size;

  // Sequencer state
  state_t            state;
  logic [WORD_W-1:0] idx;
  logic [WORD_W-1:0] cnt;
  logic              over;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  pow_k;
  logic [POS_W-1:0]  dig_pos;
  logic [SYM_W-1:0]  sym;

  // Output register
  logic             out_valid;
  logic [SYM_W-1:0] out_symbol;
  logic [POS_W-1:0] out_position;
  logic             out_is_last;

  logic [ALPHA_W-1:0]        a_eff;
  logic [LEN_W-1:0]          lo;
  logic [LEN_W-1:0]          hi;
  logic [WORD_W+ALPHA_W-1:0] prod;
  logic                      prod_over;
  logic                      cfg_wr;
  reg_idx_t                  cfg_idx;
  logic                      emit_fire;

  div_cmd_t          div_cmd;
  logic              div_by_alpha;
  logic              div_done;
  logic [WORD_W-1:0] div_quo;
  logic [WORD_W-1:0] div_rem;

  assign a_eff     = (radix == '0) ? ALPHA_W'(1) : radix;
  assign lo        = clamp_len(min_length);
  assign hi        = clamp_len(max_length);
  assign prod      = (WORD_W+ALPHA_W)'(cnt) * (WORD_W+ALPHA_W)'(a_eff);
  assign prod_over = |prod[WORD_W+ALPHA_W-1:WORD_W];
  assign emit_fire = (state == S_EMIT) && (!out_valid || text.ready);

  // Register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:ADDR_W-2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      radix      <= ALPHABET_RST;
      min_length <= MIN_LEN_RST;
      max_length <= MAX_LEN_RST;
      space_size <= SPACE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ALPHABET: radix      <= pwdata[ALPHA_W-1:0];
        REG_MIN_LEN:  min_length <= pwdata[LEN_W-1:0];
        REG_MAX_LEN:  max_length <= pwdata[LEN_W-1:0];
        REG_SPACE:    space_size <= pwdata[WORD_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ALPHABET: prdata = DATA_W'(radix);
      REG_MIN_LEN:  prdata = DATA_W'(min_length);
      REG_MAX_LEN:  prdata = DATA_W'(max_length);
      REG_SPACE:    prdata = DATA_W'(space_size);
      default:      prdata = '0;
    endcase
  end

  // Shared divider: modulo by space_size, then digits by the alphabet
  assign div_cmd.start  = (state == S_MOD_START) || (state == S_DIG_START);
  assign div_cmd.narrow = (state == S_DIG_START);
  assign div_by_alpha   = (state == S_DIG_START) || (state == S_DIG_WAIT);

  rrit_div u_div (
    .clk       (clk),
    .rst       (rst),
    .cmd       (div_cmd),
    .dividend  (idx),
    .divisor   (div_by_alpha ? WORD_W'(a_eff) : space_size),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Load the output register on an emit, clear it once taken
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && text.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (digest.valid) begin
            idx   <= digest.digest_word + WORD_W'(digest.column);
            cnt   <= WORD_W'(1);
            over  <= 1'b0;
            pow_k <= '0;
            state <= (space_size == '0) ? S_POW : S_MOD_START;
          end
        end
        S_MOD_START: state <= S_MOD_WAIT;
        S_MOD_WAIT: begin
          if (div_done) begin
            idx   <= div_rem;
            state <= S_POW;
          end
        end
        // Raise the alphabet to the shortest length
        S_POW: begin
          if (pow_k == lo) begin
            len   <= lo;
            state <= S_SEARCH;
          end else begin
            cnt   <= prod[WORD_W-1:0];
            over  <= over | prod_over;
            pow_k <= pow_k + LEN_W'(1);
          end
        end
        // Drop whole shorter lengths from the index
        S_SEARCH: begin
          if ((len < hi) && !over && (idx >= cnt)) begin
            idx  <= idx - cnt;
            len  <= len + LEN_W'(1);
            cnt  <= prod[WORD_W-1:0];
            over <= over | prod_over;
          end else begin
            dig_pos <= POS_W'(len - LEN_W'(1));
            state   <= S_DIG_START;
          end
        end
        S_DIG_START: state <= S_DIG_WAIT;
        S_DIG_WAIT: begin
          if (div_done) begin
            idx   <= div_quo;
            sym   <= div_rem[SYM_W-1:0];
            state <= S_EMIT;
          end
        end
        // Hand the symbol to the output register once it is free
        S_EMIT: begin
          if (emit_fire) begin
            out_symbol   <= sym;
            out_position <= dig_pos;
            out_is_last  <= (dig_pos == '0);
            if (dig_pos == '0) begin
              state <= S_IDLE;
            end else begin
              dig_pos <= dig_pos - POS_W'(1);
              state   <= S_DIG_START;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign digest.ready  = (state == S_IDLE);
  assign text.valid    = out_valid;
  assign text.symbol   = out_symbol;
  assign text.position = out_position;
  assign text.is_last  = out_is_last;

endmodule

@@ hw/rtl/rrit_div.sv @@
// Shared restoring divider: one quotient bit per cycle against a 64-bit
// divisor, or eight bits per cycle against a 9-bit divisor. Depends on rrit_pkg.
module rrit_div (
  input  logic                          clk,
  input  logic                          rst,
  input  rrit_pkg::div_cmd_t            cmd,
  input  logic [rrit_pkg::WORD_W-1:0]   dividend,
  input  logic [rrit_pkg::WORD_W-1:0]   divisor,
  output logic                          done,
  output logic [rrit_pkg::WORD_W-1:0]   quotient,
  output logic [rrit_pkg::WORD_W-1:0]   remainder
);
  import rrit_pkg::*;

  logic [WORD_W-1:0]    quo;
  logic [WORD_W-1:0]    rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 narrow;

  logic [WORD_W-1:0]    quo_next;
  logic [WORD_W-1:0]    rem_next;
  logic [DIV_CNT_W-1:0] cnt_next;

  logic [WORD_W:0]      wide_t;
  logic [ALPHA_W:0]     nt;
  logic [ALPHA_W-1:0]   nr;
  logic [WORD_W-1:0]    nq;

  // One step: a wide compare-subtract or a short chain of narrow ones
  always_comb begin
    wide_t   = {rem, quo[WORD_W-1]};
    nr       = rem[ALPHA_W-1:0];
    nq       = quo;
    nt       = '0;
    quo_next = quo;
    rem_next = rem;
    if (narrow) begin
      for (int i = 0; i < NARROW_BITS; i++) begin
        nt = {nr, nq[WORD_W-1]};
        nq = {nq[WORD_W-2:0], 1'b0};
        if (nt >= {1'b0, divisor[ALPHA_W-1:0]}) begin
          nt    = nt - {1'b0, divisor[ALPHA_W-1:0]};
          nq[0] = 1'b1;
        end
        nr = nt[ALPHA_W-1:0];
      end
      quo_next = nq;
      rem_next = WORD_W'(nr);
      cnt_next = cnt - DIV_CNT_W'(NARROW_BITS);
    end else begin
      if (wide_t >= {1'b0, divisor}) begin
        rem_next = WORD_W'(wide_t - {1'b0, divisor});
        quo_next = {quo[WORD_W-2:0], 1'b1};
      end else begin
        rem_next = wide_t[WORD_W-1:0];
        quo_next = {quo[WORD_W-2:0], 1'b0};
      end
      cnt_next = cnt - DIV_CNT_W'(1);
    end
  end

  // Load on start, step while the count runs, flag the last step
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        quo    <= dividend;
        rem    <= '0;
        cnt    <= DIV_CNT_W'(WORD_W);
        narrow <= cmd.narrow;
      end else if (cnt != '0) begin
        quo  <= quo_next;
        rem  <= rem_next;
        cnt  <= cnt_next;
        done <= (cnt_next == '0);
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

@@ hw/rtl/rrit_check.sv @@
// Port-level checker for the rainbow reduction block, bound to its top level.
// Depends on rrit_pkg and the assertion macro header.
`include "rainbow_reduction_index_to_text_top_macros.svh"

module rrit_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rrit_pkg::SYM_W-1:0]  symbol,
  input logic [rrit_pkg::POS_W-1:0]  position,
  input logic                        is_last,
  input logic                        pready
);
  import rrit_pkg::*;

  logic [SYM_W+POS_W:0] fields;

  assign fields = {symbol, position, is_last};

  // One item at a time: input closes right after a transfer
  `RRIT_ASSERT_NEXT(a_in_closes, clk, rst, in_valid && in_ready, !in_ready)

  // No new item while a text is still being emitted
  `RRIT_ASSERT_SAME(a_busy_mid_text, clk, rst, out_valid && !is_last, !in_ready)

  // The end mark sits on position zero and nowhere else
  `RRIT_ASSERT_SAME(a_last_at_zero, clk, rst, out_valid, is_last == (position == '0))

  // A stalled result holds
  `RRIT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(fields))

  // Register port never waits
  `RRIT_ASSERT_SAME(a_pready, clk, rst, 1'b1, pready)

endmodule

bind rainbow_reduction_index_to_text_top rrit_check u_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (digest.valid),
  .in_ready  (digest.ready),
  .out_valid (text.valid),
  .out_ready (text.ready),
  .symbol    (text.symbol),
  .position  (text.position),
  .is_last   (text.is_last),
  .pready    (pready)
);
